// ----- rtl/core/tci_pkg.sv -----
// Shared constants and the cosine table for the tide cosine interpolator.
// The table is built at elaboration with fixed-point integer math only.
// Used by tci_cos_rom and tide_cosine_interpolator_core.
package tci_pkg;

  localparam int MAX_POINTS  = 8;
  localparam int PT_IDX_W    = $clog2(MAX_POINTS);
  localparam int COS_ENTRIES = 1024;
  localparam int COS_BITS    = $clog2(COS_ENTRIES);
  localparam int Q_BITS      = 15;
  localparam int COS_W       = 18;

  localparam logic [3:0]         PTS_RESET      = 4'd2;
  localparam logic signed [15:0] NOT_FOUND_H    = -16'sd9999;
  localparam logic [16:0]        HDIV           = 17'd131070;
  localparam logic [16:0]        COS_OFFSET     = 17'd65535;
  localparam int                 HDIV_STEPS     = 16;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam longint unsigned PI_Q60  = 64'h3243F6A8885A308D;
  // angle step per table entry, whole part and leftover
  localparam longint unsigned PI_STEP = PI_Q60 / COS_ENTRIES;
  localparam longint unsigned PI_REM  = PI_Q60 % COS_ENTRIES;

  typedef logic signed [COS_W-1:0] cos_tab_t [COS_ENTRIES];

  // (a*b) >> 60
  function automatic longint unsigned fmul(longint unsigned a, longint unsigned b);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    return p[123:60];
  endfunction

  // unsigned a / b by shift and subtract, elaboration only
  function automatic longint unsigned udiv64(longint unsigned a, longint unsigned b);
    logic [64:0]     r;
    longint unsigned q;
    r = '0;
    q = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], a[i]};
      if (r >= {1'b0, b}) begin
        r = r - {1'b0, b};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // round(65535*cos(pi*k/COS_ENTRIES)) for 2k <= COS_ENTRIES
  function automatic int cos_mag(int k);
    longint unsigned kk, x, x2, term, v, r, dv;
    longint          sum;
    kk = longint'(k);
    x = PI_STEP * kk + ((PI_REM * kk) >> COS_BITS);
    x2 = fmul(x, x);
    term = 64'd1 << 60;
    sum = longint'(term);
    for (int i = 1; i <= 30; i++) begin
      if (term != 0) begin
        dv = longint'((2 * i - 1) * (2 * i));
        term = udiv64(fmul(term, x2), dv);
        if ((i & 1) == 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
    end
    if (sum < 0) sum = 0;
    v = longint'(sum) >> 16;
    r = (v * 64'd65535 + (64'd1 << 43)) >> 44;
    return int'(r);
  endfunction

  function automatic cos_tab_t build_cos();
    cos_tab_t t;
    for (int k = 0; k < COS_ENTRIES; k++) begin
      if (2 * k <= COS_ENTRIES) t[k] = COS_W'(-cos_mag(k));
      else t[k] = COS_W'(cos_mag(COS_ENTRIES - k));
    end
    return t;
  endfunction

  localparam cos_tab_t COS_ROM = build_cos();

endpackage

// ----- rtl/core/tci_cos_rom.sv -----
// Cosine lookup table with a registered read port.
// Contents come from tci_pkg::COS_ROM.
module tci_cos_rom (
  input  logic                               clk,
  input  logic [tci_pkg::COS_BITS-1:0]       addr,
  output logic signed [tci_pkg::COS_W-1:0]   data
);

  always_ff @(posedge clk) begin
    data <= tci_pkg::COS_ROM[addr];
  end

endmodule

// ----- rtl/core/tide_cosine_interpolator_core.sv -----
// Tide cosine interpolator: point table, scan sequencer and shared divide unit.
// Depends on tci_pkg and tci_cos_rom.
//
// Usage: the input channel carries write beats (func = 0) that store one tide
// point in a slot, and query beats (func = 1) that ask for the height at a
// time. A write yields nothing. A query yields one beat on
// the output channel: found and tide_height (-9999 when no point pair brackets
// the query time). cfg_we/cfg_data set how many points a query scans.
// A query scans the points in use (one table read per cycle), then works out
// the quotient bits, reads the ROM, multiplies, runs the height divide and
// adds; with fewer than two points in use it goes straight to the output.
// Both divides run on one shared subtractor.
// in_stall is high while a query is in work. A finished result sits in the
// output register; the block keeps accepting beats while it waits, and a later
// query holds its result until the earlier one is taken.
// Reset (rst, synchronous) clears all points to zero, sets points in use to 2
// and empties the output register.
module tide_cosine_interpolator_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               func,
  input  logic [2:0]         point_index,
  input  logic [15:0]        point_time,
  input  logic signed [15:0] point_height,
  input  logic [15:0]        query_time,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               found,
  output logic signed [15:0] tide_height
);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_PREP, S_DIVQ, S_ROM, S_MUL, S_ABS, S_DIVH, S_SUM, S_OUT
  } state_t;

  state_t state;

  logic [15:0]        ev_t [tci_pkg::MAX_POINTS];
  logic signed [15:0] ev_h [tci_pkg::MAX_POINTS];
  logic [3:0]         pts;

  logic [3:0]         cnt;
  logic [15:0]        qt;
  logic [15:0]        prev_t, t1, t2;
  logic signed [15:0] prev_h, h1, h2;
  logic               hit;
  logic [15:0]        dd;
  logic [33:0]        rem;
  logic [33:0]        dsh;
  logic [tci_pkg::Q_BITS-1:0] qv;
  logic [15:0]        quot;
  logic signed [34:0] prod;
  logic               neg;
  logic               res_found;
  logic signed [15:0] res_h;

  logic signed [tci_pkg::COS_W-1:0] cos_val;

  logic [3:0]   n_eff;
  logic [15:0]  cur_t;
  logic signed [15:0] cur_h;
  logic         hit_now;
  logic [33:0]  sub_a, sub_b;
  logic [34:0]  sub_full;
  logic         ge;
  logic [16:0]  rem_sh;
  logic         in_acc;
  logic         out_free;
  logic signed [16:0] diff_h;
  logic signed [17:0] cos_p;
  logic signed [16:0] sq;
  logic signed [16:0] hsum;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign n_eff   = (pts > 4'(tci_pkg::MAX_POINTS)) ? 4'(tci_pkg::MAX_POINTS) : pts;
  assign cur_t   = ev_t[cnt[tci_pkg::PT_IDX_W-1:0]];
  assign cur_h   = ev_h[cnt[tci_pkg::PT_IDX_W-1:0]];
  assign hit_now = (cnt != 4'd0) && (prev_t < qt) && (cur_t > qt);

  // shared subtract/compare unit for both restoring divides
  assign rem_sh = {rem[15:0], 1'b0};
  always_comb begin
    if (state == S_DIVH) begin
      sub_a = rem;
      sub_b = dsh;
    end else begin
      sub_a = {17'd0, rem_sh};
      sub_b = {18'd0, dd};
    end
  end
  assign sub_full = {1'b0, sub_a} - {1'b0, sub_b};
  assign ge       = !sub_full[34];

  assign diff_h = 17'(h2) - 17'(h1);
  assign cos_p  = 18'(cos_val) + 18'(tci_pkg::COS_OFFSET);
  assign sq     = neg ? -17'({1'b0, quot}) : 17'({1'b0, quot});
  assign hsum   = 17'(h1) + sq;

  tci_cos_rom u_rom (
    .clk  (clk),
    .addr (qv[tci_pkg::Q_BITS-1 -: tci_pkg::COS_BITS]),
    .data (cos_val)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < tci_pkg::MAX_POINTS; i++) begin
        ev_t[i] <= '0;
        ev_h[i] <= '0;
      end
    end else if (in_acc && func == tci_pkg::FUNC_WRITE) begin
      ev_t[point_index] <= point_time;
      ev_h[point_index] <= point_height;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) pts <= tci_pkg::PTS_RESET;
    else if (cfg_we) pts <= cfg_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // S_OUT drives out_valid itself
      if (state != S_OUT && out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_acc && func == tci_pkg::FUNC_QUERY) begin
            qt  <= query_time;
            cnt <= '0;
            hit <= 1'b0;
            if (n_eff < 4'd2) begin
              res_found <= 1'b0;
              res_h     <= tci_pkg::NOT_FOUND_H;
              state     <= S_OUT;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          prev_t <= cur_t;
          prev_h <= cur_h;
          if (hit_now) begin
            hit <= 1'b1;
            t1  <= prev_t;
            t2  <= cur_t;
            h1  <= prev_h;
            h2  <= cur_h;
          end
          cnt <= cnt + 4'd1;
          if (cnt == n_eff - 4'd1) begin
            if (hit || hit_now) begin
              state <= S_PREP;
            end else begin
              res_found <= 1'b0;
              res_h     <= tci_pkg::NOT_FOUND_H;
              state     <= S_OUT;
            end
          end
        end
        S_PREP: begin
          rem   <= 34'(qt - t1);
          dd    <= t2 - t1;
          cnt   <= '0;
          state <= S_DIVQ;
        end
        S_DIVQ: begin
          qv  <= {qv[tci_pkg::Q_BITS-2:0], ge};
          rem <= ge ? sub_full[33:0] : {17'd0, rem_sh};
          cnt <= cnt + 4'd1;
          if (cnt == 4'(tci_pkg::Q_BITS - 1)) state <= S_ROM;
        end
        S_ROM: begin
          state <= S_MUL;  // table read in flight
        end
        S_MUL: begin
          prod  <= 35'(diff_h) * 35'(cos_p);
          state <= S_ABS;
        end
        S_ABS: begin
          neg   <= prod[34];
          rem   <= prod[34] ? 34'(-prod) : prod[33:0];
          dsh   <= 34'(tci_pkg::HDIV) << (tci_pkg::HDIV_STEPS - 1);
          cnt   <= '0;
          state <= S_DIVH;
        end
        S_DIVH: begin
          quot <= {quot[14:0], ge};
          if (ge) rem <= sub_full[33:0];
          dsh <= dsh >> 1;
          cnt <= cnt + 4'd1;
          if (cnt == 4'(tci_pkg::HDIV_STEPS - 1)) state <= S_SUM;
        end
        S_SUM: begin
          res_found <= 1'b1;
          res_h     <= hsum[15:0];
          state     <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            found       <= res_found;
            tide_height <= res_h;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/tci_checker.sv -----
// Port-level checks for tide_cosine_interpolator_core, bound into that module.
// Sees only the core's ports.
module tci_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               func,
  input logic               out_valid,
  input logic               out_stall,
  input logic               found,
  input logic signed [15:0] tide_height
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(tide_height) && $stable(found))
    else $error("stalled output beat changed");

  a_not_found: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> tide_height == -16'sd9999)
    else $error("not-found beat without marker height");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && func |=> in_stall)
    else $error("query accepted but block not busy");

  a_reset_ready: assert property (@(posedge clk)
    $past(rst) && !rst |-> !in_stall && !out_valid)
    else $error("block not idle after reset");

endmodule

bind tide_cosine_interpolator_core tci_checker u_tci_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .func        (func),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .found       (found),
  .tide_height (tide_height)
);

// ----- verif/tb_top.sv -----
// Testbench for tide_cosine_interpolator_core: drives write and query beats,
// predicts each query result and checks it beat by beat.
// Depends on tci_pkg and the core RTL only.
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT  = 5000;
  localparam int SETTLE_CYC  = 64;
  localparam int NPTS        = 8;

  typedef struct packed {
    logic               found;
    logic signed [15:0] height;
  } reading_t;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [3:0]         cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic               func;
  logic [2:0]         point_index;
  logic [15:0]        point_time;
  logic signed [15:0] point_height;
  logic [15:0]        query_time;
  logic               out_valid;
  logic               out_stall;
  logic               found;
  logic signed [15:0] tide_height;

  tide_cosine_interpolator_core dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .func         (func),
    .point_index  (point_index),
    .point_time   (point_time),
    .point_height (point_height),
    .query_time   (query_time),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .found        (found),
    .tide_height  (tide_height)
  );

  // predictor state
  logic [15:0]        tbl_time [NPTS];
  logic signed [15:0] tbl_height [NPTS];
  logic [3:0]         scan_count;
  int                 half_cos [1024];
  reading_t           pending_readings [$];

  int err_count;
  int idle_pct;
  int stall_pct;
  int hold_req;
  int hold_left;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // round(65535*cos(pi*k/1024)) for k <= 512, Q60 Taylor series
  function automatic int cos_scaled(int k);
    logic [127:0]    prod;
    longint unsigned pi_q, ang, ang2, term, v, r;
    longint          acc;
    pi_q = 64'h3243F6A8885A308D;
    ang  = (pi_q / 1024) * longint'(k) + ((pi_q % 1024) * longint'(k)) / 1024;
    prod = 128'(ang) * 128'(ang);
    ang2 = prod[123:60];
    term = 64'd1 << 60;
    acc  = longint'(term);
    for (int i = 1; i <= 30; i++) begin
      if (term != 0) begin
        prod = 128'(term) * 128'(ang2);
        term = prod[123:60] / longint'((2 * i - 1) * (2 * i));
        if (i % 2 == 1) acc = acc - longint'(term);
        else acc = acc + longint'(term);
      end
    end
    if (acc < 0) acc = 0;
    v = longint'(acc) >> 16;
    r = (v * 64'd65535 + (64'd1 << 43)) >> 44;
    return int'(r);
  endfunction

  task automatic reset_predictor();
    for (int i = 0; i < NPTS; i++) begin
      tbl_time[i] = '0;
      tbl_height[i] = '0;
    end
    scan_count = tci_pkg::PTS_RESET;
    for (int k = 0; k < 1024; k++)
      half_cos[k] = (2 * k <= 1024) ? -cos_scaled(k) : cos_scaled(1024 - k);
  endtask

  // apply one accepted beat to the predictor
  task automatic tide_predict(logic f, logic [2:0] idx, logic [15:0] pt,
                              logic signed [15:0] ph, logic [15:0] qt);
    int       n, t1, t2, h1, h2, q, c;
    logic     hit;
    longint   num, h;
    reading_t r;
    if (f == tci_pkg::FUNC_WRITE) begin
      tbl_time[idx] = pt;
      tbl_height[idx] = ph;
    end else begin
      n = (scan_count > NPTS) ? NPTS : scan_count;
      hit = 1'b0;
      t1 = 0; t2 = 0; h1 = 0; h2 = 0;
      for (int i = 1; i < n; i++) begin
        if (tbl_time[i-1] < qt && tbl_time[i] > qt) begin
          hit = 1'b1;
          t1 = tbl_time[i-1];
          t2 = tbl_time[i];
          h1 = tbl_height[i-1];
          h2 = tbl_height[i];
        end
      end
      if (!hit) begin
        r.found = 1'b0;
        r.height = tci_pkg::NOT_FOUND_H;
      end else begin
        q = int'((longint'(int'(qt) - t1) << 15) / longint'(t2 - t1));
        c = half_cos[q >> 5];
        num = longint'(h2 - h1) * longint'(c + 65535);
        h = longint'(h1) + num / 64'sd131070;
        r.found = 1'b1;
        r.height = h[15:0];
      end
      pending_readings.push_back(r);
    end
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    err_count++;
  endtask

  // one input beat; called right after a rising edge
  task automatic send_beat(logic f, logic [2:0] idx, logic [15:0] pt,
                           logic signed [15:0] ph, logic [15:0] qt);
    logic take;
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    func         <= f;
    point_index  <= idx;
    point_time   <= pt;
    point_height <= ph;
    query_time   <= qt;
    do begin
      @(negedge clk);
      take = !in_stall;
      @(posedge clk);
    end while (!take);
    tide_predict(f, idx, pt, ph, qt);
  endtask

  task automatic release_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    release_input();
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_scan_count(logic [3:0] v);
    wait_drained();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    scan_count = v;
    @(posedge clk);
  endtask

  task automatic put_point(int idx, int t, int h);
    send_beat(tci_pkg::FUNC_WRITE, 3'(idx), 16'(t), 16'(h), 16'($urandom));
  endtask

  task automatic ask(int t);
    send_beat(tci_pkg::FUNC_QUERY, 3'($urandom), 16'($urandom), 16'($urandom), 16'(t));
  endtask

  // cleared table, default scan of two points
  task automatic test_reset_state();
    ask(0);
    ask(1);
    ask(16'hFFFF);
  endtask

  task automatic test_directed_cases();
    put_point(0, 0, -32768);
    put_point(1, 65535, 32767);
    ask(0);          // at t1: no bracket
    ask(65535);      // at t2: no bracket
    ask(1);
    ask(32768);
    ask(65534);
    put_point(0, 100, 32767);
    put_point(1, 101, -32768);
    ask(100);        // gap of one: nothing strictly inside
    put_point(1, 100, 5);
    ask(100);        // equal times
    put_point(0, 500, 7);
    put_point(1, 200, -7);
    ask(300);        // reversed pair
    put_point(0, 1000, -20000);
    put_point(1, 3000, 20000);
    ask(1500);
    ask(2999);
    ask(1001);
  endtask

  task automatic fill_sorted(output int times [NPTS]);
    int tq [$];
    for (int i = 0; i < NPTS; i++) tq.push_back($urandom_range(65535));
    tq.sort();
    for (int i = 0; i < NPTS; i++) begin
      times[i] = tq[i];
      put_point(i, tq[i], int'($urandom_range(65535)) - 32768);
    end
  endtask

  task automatic test_register_settings();
    logic [3:0] settings [7] = '{4'd0, 4'd1, 4'd2, 4'd3, 4'd8, 4'd9, 4'd15};
    int times [NPTS];
    foreach (settings[s]) begin
      write_scan_count(settings[s]);
      fill_sorted(times);
      for (int j = 0; j < 6; j++)
        ask($urandom_range(times[NPTS-1], times[0]));
      ask(times[3]);
    end
  endtask

  task automatic test_random_traffic(int idle, int stall, int beats);
    int sent, times [NPTS];
    idle_pct = idle;
    stall_pct = stall;
    sent = 0;
    while (sent < beats) begin
      if ($urandom_range(9) < 7) begin
        // well-formed: sorted table then queries across it
        fill_sorted(times);
        sent += NPTS;
        repeat ($urandom_range(8, 3)) begin
          if ($urandom_range(7) == 0) ask(times[$urandom_range(NPTS-1)]);
          else ask($urandom_range(times[NPTS-1], times[0]));
          sent++;
        end
      end else begin
        repeat ($urandom_range(6, 1)) begin
          send_beat(1'($urandom), 3'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom));
          sent++;
        end
      end
    end
    write_scan_count(4'($urandom_range(15)));
    write_scan_count(4'd8);
  endtask

  // long receiver hold-off while queries keep coming, then a full pause
  task automatic test_output_backpressure();
    int times [NPTS];
    idle_pct = 0;
    stall_pct = 0;
    fill_sorted(times);
    hold_req = 400;
    repeat (12) ask($urandom_range(times[NPTS-1], times[0]));
    wait_drained();
    repeat (5) ask($urandom_range(times[NPTS-1], times[0]));
    wait_drained();
  endtask

  // receiver stall and hold-off
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // result checker; stall and payload are stable around the falling edge
  always @(negedge clk) begin
    reading_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_readings.size() == 0) begin
        report_mismatch("unexpected beat, found", found, -1);
      end else begin
        want = pending_readings.pop_front();
        if (found !== want.found) report_mismatch("found", found, want.found);
        if (tide_height !== want.height)
          report_mismatch("tide_height", tide_height, want.height);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    func = 1'b0;
    point_index = '0;
    point_time = '0;
    point_height = '0;
    query_time = '0;
    out_stall = 1'b0;
    err_count = 0;
    idle_pct = 0;
    stall_pct = 0;
    hold_req = 0;
    hold_left = 0;
    idle_cycles = 0;
    reset_predictor();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_directed_cases();
    test_register_settings();
    test_random_traffic(0, 0, 420);
    test_random_traffic(50, 0, 420);
    test_random_traffic(0, 50, 420);
    test_random_traffic(9, 9, 420);
    test_output_backpressure();

    wait_drained();
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
rtl/core/tci_pkg.sv
rtl/core/tci_cos_rom.sv
rtl/core/tide_cosine_interpolator_core.sv
rtl/core/tci_checker.sv
verif/tb_top.sv
